// ===== sv/lgr_pkg.sv =====
// Shared types, opcodes and constant tables for the LED glyph renderer.
// No dependencies.
`default_nettype none

package lgr_pkg;

    localparam int SEGMENTS_PER_DIGIT = 21;
    localparam int IDX_W              = 7;
    localparam int GLYPH_FIRST        = 40;
    localparam int GLYPH_LAST         = 90;
    localparam int GLYPH_ROWS         = GLYPH_LAST - GLYPH_FIRST + 1;
    localparam int COLON_BASE         = 42;
    localparam int COLON_SHIFT        = 2;
    localparam int COLON_DIGIT        = 4;

    localparam logic [1:0] OP_SET_SEG   = 2'd0;
    localparam logic [1:0] OP_SET_GLYPH = 2'd1;
    localparam logic [1:0] OP_READ      = 2'd2;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } lgr_rgb_t;

    // One frame store access issued by the sequencer.
    typedef struct packed {
        logic             valid;
        logic             write;
        logic             read;
        logic             rej;
        logic             last;
        logic [IDX_W-1:0] idx;
        lgr_rgb_t         colour;
    } lgr_req_t;

    localparam logic [4:0] SEG_PERM [SEGMENTS_PER_DIGIT] = '{
        5'd0, 5'd1, 5'd2, 5'd17, 5'd3, 5'd16, 5'd4, 5'd15, 5'd5, 5'd18, 5'd19,
        5'd20, 5'd14, 5'd6, 5'd13, 5'd7, 5'd12, 5'd8, 5'd11, 5'd10, 5'd9
    };

    // Leftmost bit is segment 0.
    localparam logic [20:0] GLYPH_ROM [GLYPH_ROWS] = '{
        21'b100101010000101010100, 21'b001010101000010101001,
        21'b001010000000000000000, 21'b010000000111000000010,
        21'b000000000000000101000, 21'b000000000111000000000,
        21'b000000000000000001000, 21'b000010101111101010000,
        21'b111111111000111111111, 21'b000010101000010101000,
        21'b111010101111101010111, 21'b111010101111010101111,
        21'b000111111111010101000, 21'b111101010111010101111,
        21'b111101010111111111111, 21'b111010101000010101000,
        21'b111111111111111111111, 21'b111111111111010101111,
        21'b000000100000000100000, 21'b000000100000000101000,
        21'b000000001111010000000, 21'b111000000000000000111,
        21'b000000010111100000000, 21'b111010101111101010010,
        21'b111110101111111111111, 21'b111111111111111111000,
        21'b000101010111111111111, 21'b111101010000101010111,
        21'b000010101111111111111, 21'b111101010111101010111,
        21'b111101010111101010000, 21'b111101010000111111111,
        21'b000111111111111111000, 21'b000101010000101010000,
        21'b000010101000111111111, 21'b000101011111111010000,
        21'b000101010000101010111, 21'b101111111010111111000,
        21'b100111111010111111001, 21'b111111111000111111111,
        21'b111111111111101010000, 21'b111111111111010101000,
        21'b000000000111101010000, 21'b111101010111010101111,
        21'b000101010111101010111, 21'b000111111000111111111,
        21'b000111111000110000010, 21'b000111111010111111101,
        21'b000111100010001111000, 21'b000111111111010101111,
        21'b111010100010001010111
    };

    // LED index for a digit slot and segment; caller checks the ranges.
    function automatic logic [7:0] map_led(input logic [2:0] digit, input logic [4:0] pos);
        logic [7:0] base;
        logic [7:0] id;
        base = 8'(digit) * 8'(SEGMENTS_PER_DIGIT);
        if (digit == 3'(COLON_DIGIT))
        begin
            id = 8'(pos) + 8'(COLON_BASE);
        end
        else if (digit >= 3'd2)
        begin
            id = base + 8'(SEG_PERM[pos]) + 8'(COLON_SHIFT);
        end
        else
        begin
            id = base + 8'(SEG_PERM[pos]);
        end
        return id;
    endfunction

endpackage

`default_nettype wire

// ===== sv/lgr_scale.sv =====
// Brightness saturation and color scaling, c*b/255 rounded to nearest.
// Depends on lgr_pkg.
`default_nettype none

module lgr_scale
    import lgr_pkg::*;
(
    input  wire logic [7:0]         red,
    input  wire logic [7:0]         green,
    input  wire logic [7:0]         blue,
    input  wire logic signed [15:0] brightness,
    output lgr_rgb_t                colour
);

    logic [7:0] bright;

    // t = c*b + 128; (t + (t >> 8)) >> 8 is exact for 8-bit operands
    function automatic logic [7:0] scale8(input logic [7:0] c, input logic [7:0] b);
        logic [15:0] t;
        logic [15:0] s;
        t = 16'(c) * 16'(b) + 16'd128;
        s = t + (t >> 8);
        return s[15:8];
    endfunction

    always_comb
    begin
        if (brightness[15])
        begin
            bright = 8'd0;
        end
        else if (brightness[14:8] != 7'd0)
        begin
            bright = 8'hff;
        end
        else
        begin
            bright = brightness[7:0];
        end
    end

    assign colour.r = scale8(red, bright);
    assign colour.g = scale8(green, bright);
    assign colour.b = scale8(blue, bright);

endmodule

`default_nettype wire

// ===== sv/lgr_seq.sv =====
// Command register and segment sequencer: decodes one transaction and issues
// one frame store access per cycle while the frame store advances (21 for a glyph). Depends on lgr_pkg.
`default_nettype none

module lgr_seq
    import lgr_pkg::*;
#(
    parameter int LED_COUNT = 86
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] op,
    input  wire logic [2:0] digit,
    input  wire logic [4:0] position,
    input  wire logic [7:0] character,
    input  wire logic [6:0] pixel_index,
    input  wire lgr_rgb_t   lit,
    input  wire logic       adv,
    output lgr_req_t        req
);

    typedef enum logic [1:0] {K_SEG, K_GLYPH, K_READ, K_REJ} kind_t;

    localparam logic [7:0] LED_LIMIT = 8'(LED_COUNT);
    localparam logic [4:0] LAST_SEG  = 5'(SEGMENTS_PER_DIGIT - 1);

    logic             busy_reg, busy_next;
    kind_t            kind_reg, kind_next;
    logic [2:0]       digit_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    lgr_rgb_t         col_reg;
    logic [20:0]      row_reg;
    logic [4:0]       cnt_reg, cnt_next;

    logic       accept;
    logic       done;
    logic [7:0] seg_id;
    logic [7:0] glyph_id;
    logic [5:0] row_sel;
    logic       lit_bit;

    assign seg_id   = map_led(digit, position);
    assign glyph_id = map_led(digit_reg, cnt_reg);
    assign row_sel  = 6'(character - 8'(GLYPH_FIRST));
    assign lit_bit  = row_reg[5'(SEGMENTS_PER_DIGIT - 1) - cnt_reg];

    always_comb
    begin
        req.valid  = busy_reg;
        req.write  = (kind_reg == K_SEG) || (kind_reg == K_GLYPH);
        req.read   = (kind_reg == K_READ);
        req.rej    = (kind_reg == K_REJ);
        req.last   = (kind_reg != K_GLYPH) || (cnt_reg == LAST_SEG);
        req.idx    = idx_reg;
        req.colour = '0;
        case (kind_reg)
            K_SEG:   req.colour = col_reg;
            K_GLYPH:
            begin
                req.idx    = glyph_id[IDX_W-1:0];
                req.colour = lit_bit ? col_reg : '0;
            end
            default: req.colour = '0;
        endcase
    end

    assign done     = busy_reg && req.last && adv;
    assign in_stall = busy_reg && !done;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        kind_next = K_REJ;
        idx_next  = '0;
        case (op)
            OP_SET_SEG:
            begin
                if (digit <= 3'(COLON_DIGIT) && position < 5'(SEGMENTS_PER_DIGIT)
                    && seg_id < LED_LIMIT)
                begin
                    kind_next = K_SEG;
                    idx_next  = seg_id[IDX_W-1:0];
                end
            end
            OP_SET_GLYPH:
            begin
                if (digit < 3'(COLON_DIGIT) && character >= 8'(GLYPH_FIRST)
                    && character <= 8'(GLYPH_LAST))
                begin
                    kind_next = K_GLYPH;
                end
            end
            OP_READ:
            begin
                if ({1'b0, pixel_index} < LED_LIMIT)
                begin
                    kind_next = K_READ;
                    idx_next  = pixel_index;
                end
            end
            default: kind_next = K_REJ;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && adv)
        begin
            cnt_next = cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind_next;
            digit_reg <= digit;
            idx_reg   <= idx_next;
            col_reg   <= lit;
            row_reg   <= (kind_next == K_GLYPH) ? GLYPH_ROM[row_sel] : '0;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lgr_frame.sv =====
// Frame store with registered synchronous read, per-entry written flags, and
// the result register. Depends on lgr_pkg.
`default_nettype none

module lgr_frame
    import lgr_pkg::*;
#(
    parameter int LED_COUNT = 86
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire lgr_req_t req,
    output logic          adv,
    output logic          out_valid,
    input  wire logic     out_stall,
    output logic [6:0]    led_index,
    output logic [7:0]    out_red,
    output logic [7:0]    out_green,
    output logic [7:0]    out_blue,
    output logic          is_read,
    output logic          rejected,
    output logic          last
);

    localparam int AW = $clog2(LED_COUNT);

    lgr_rgb_t         mem [LED_COUNT];
    logic             written_reg [LED_COUNT];
    logic             res_valid_reg;
    lgr_req_t         res_reg;
    lgr_rgb_t         rd_data_reg;
    logic             rd_written_reg;
    logic [AW-1:0]    addr;
    logic             take;
    lgr_rgb_t         rd_col;

    assign adv  = !res_valid_reg || !out_stall;
    assign take = adv && req.valid;
    assign addr = req.idx[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            for (int i = 0; i < LED_COUNT; i++)
            begin
                written_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (adv)
            begin
                res_valid_reg <= req.valid;
            end
            if (take && req.write)
            begin
                written_reg[addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (req.write)
            begin
                mem[addr] <= req.colour;
            end
            rd_data_reg    <= mem[addr];
            rd_written_reg <= written_reg[addr];
            res_reg        <= req;
        end
    end

    assign rd_col = rd_written_reg ? rd_data_reg : '0;

    assign out_valid = res_valid_reg;
    assign led_index = res_reg.idx;
    assign out_red   = res_reg.read ? rd_col.r : res_reg.colour.r;
    assign out_green = res_reg.read ? rd_col.g : res_reg.colour.g;
    assign out_blue  = res_reg.read ? rd_col.b : res_reg.colour.b;
    assign is_read   = res_reg.read;
    assign rejected  = res_reg.rej;
    assign last      = res_reg.last;

endmodule

`default_nettype wire

// ===== sv/led_glyph_renderer.sv =====
// LED glyph renderer top level: color scaling, sequencer and frame store.
// Depends on lgr_pkg, lgr_scale, lgr_seq, lgr_frame.
//
//  channel  direction  handshake             payload
//  input    in         in_valid / in_stall   op digit position character pixel_index
//                                            red green blue brightness
//  output   out        out_valid / out_stall led_index out_red out_green out_blue
//                                            is_read rejected last
//
// Segment write, read and rejected transactions each make one frame store access; a glyph
// makes 21, one per cycle through the single memory port while the output does not stall.
// An input transaction is held in the command register, then its first result in the result register.
// Reset clears per-LED written flags at once; unwritten LEDs read black, no sweep.
// An output stall freezes the memory stage and result register; one further
// input transaction is still taken into the command register.
`default_nettype none

module led_glyph_renderer
    import lgr_pkg::*;
#(
    parameter int LED_COUNT = 86
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         op,
    input  wire logic [2:0]         digit,
    input  wire logic [4:0]         position,
    input  wire logic [7:0]         character,
    input  wire logic [6:0]         pixel_index,
    input  wire logic [7:0]         red,
    input  wire logic [7:0]         green,
    input  wire logic [7:0]         blue,
    input  wire logic signed [15:0] brightness,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [6:0]              led_index,
    output logic [7:0]              out_red,
    output logic [7:0]              out_green,
    output logic [7:0]              out_blue,
    output logic                    is_read,
    output logic                    rejected,
    output logic                    last
);

    lgr_rgb_t lit;
    lgr_req_t req;
    logic     adv;

    lgr_scale u_scale (
        .red        (red),
        .green      (green),
        .blue       (blue),
        .brightness (brightness),
        .colour     (lit)
    );

    lgr_seq #(.LED_COUNT(LED_COUNT)) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .digit       (digit),
        .position    (position),
        .character   (character),
        .pixel_index (pixel_index),
        .lit         (lit),
        .adv         (adv),
        .req         (req)
    );

    lgr_frame #(.LED_COUNT(LED_COUNT)) u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .adv       (adv),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .led_index (led_index),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .is_read   (is_read),
        .rejected  (rejected),
        .last      (last)
    );

endmodule

`default_nettype wire

// ===== sv/lgr_checker.sv =====
// Port-level checks for led_glyph_renderer, bound to the top level.
// Depends on led_glyph_renderer.
`default_nettype none

module lgr_checker #(
    parameter int LED_COUNT = 86
)
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [6:0] led_index,
    input wire logic [7:0] out_red,
    input wire logic [7:0] out_green,
    input wire logic [7:0] out_blue,
    input wire logic       is_read,
    input wire logic       rejected,
    input wire logic       last
);

    localparam logic [7:0] LED_LIMIT = 8'(LED_COUNT);

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> last && !is_read && led_index == 7'd0
            && out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)
        else $error("rejected result not single and zeroed");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rejected |-> {1'b0, led_index} < LED_LIMIT)
        else $error("result LED index outside frame");

    a_read_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_read |-> last)
        else $error("read result without last");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(led_index) && $stable(out_red)
            && $stable(out_green) && $stable(out_blue) && $stable(last))
        else $error("stalled result changed");

endmodule

bind led_glyph_renderer lgr_checker #(.LED_COUNT(LED_COUNT)) u_lgr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .led_index (led_index),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .is_read   (is_read),
    .rejected  (rejected),
    .last      (last)
);

`default_nettype wire
